[rtl/core/lacg_pkg.sv]
// ----------------------------------------------------------------------------
// lacg_pkg: shared types for the line angle cosine gradient block
// Segment record produced by the front end and carried through the queue.
// ----------------------------------------------------------------------------
package lacg_pkg;

  // One segment after classification: direction (possibly halved), the
  // larger magnitude for normalising, and the running left-shift count.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [30:0] m;
    logic        half;
    logic [4:0]  lz;
  } nseg_t;

  typedef struct packed {
    nseg_t      s1;
    nseg_t      s2;
    logic [3:0] wrt;
    logic       deg;
  } front_t;

  localparam int QDEPTH = 2;

endpackage

[rtl/core/line_angle_cosine_gradient.sv]
// ----------------------------------------------------------------------------
// line_angle_cosine_gradient: cosine between two segments and one gradient
// Raise start with the eight Q16.16 endpoint coordinates and in_wrt_coord;
// the request is taken on any clock edge where start is high and busy low.
// One request may be taken every cycle. Each result appears on the out_
// ports for a single cycle, marked by out_strobe, after its request was
// taken, in request order. Each request passes through the datapath: a
// 32-stage square root, a 31-stage unit-vector divider and a 34-stage
// scaled divider for the gradient, plus normalising and
// multiply stages. out_cosine_residual is Q2.30, out_partial_derivative is
// saturating Q16.16 and zero when no coordinate is named (in_wrt_coord 8
// or above). A zero-length segment sets out_degenerate and zeroes both.
// The receiver cannot stall; the pipeline always advances and drains the
// intake queue every cycle, so the queue never fills and busy stays low.
// Synchronous active-low reset empties the queue and the pipeline; no
// result is produced for a request in flight at reset.
// ----------------------------------------------------------------------------
module line_angle_cosine_gradient
  import lacg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_line1_start_x,
  input  logic signed [31:0] in_line1_start_y,
  input  logic signed [31:0] in_line1_end_x,
  input  logic signed [31:0] in_line1_end_y,
  input  logic signed [31:0] in_line2_start_x,
  input  logic signed [31:0] in_line2_start_y,
  input  logic signed [31:0] in_line2_end_x,
  input  logic signed [31:0] in_line2_end_y,
  input  logic [3:0]         in_wrt_coord,
  output logic               out_strobe,
  output logic signed [31:0] out_cosine_residual,
  output logic signed [31:0] out_partial_derivative,
  output logic               out_degenerate
);

  logic   q_full, q_empty, q_push;
  front_t q_din, q_dout;
  logic [31:0] res_cos, res_deriv;

  lacg_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_line1_start_x (in_line1_start_x),
    .in_line1_start_y (in_line1_start_y),
    .in_line1_end_x   (in_line1_end_x),
    .in_line1_end_y   (in_line1_end_y),
    .in_line2_start_x (in_line2_start_x),
    .in_line2_start_y (in_line2_start_y),
    .in_line2_end_x   (in_line2_end_x),
    .in_line2_end_y   (in_line2_end_y),
    .in_wrt_coord     (in_wrt_coord),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_din)
  );

  lacg_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (~q_empty),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  lacg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_v       (~q_empty),
    .in_d       (q_dout),
    .res_strobe (out_strobe),
    .res_cos    (res_cos),
    .res_deriv  (res_deriv),
    .res_deg    (out_degenerate)
  );

  assign out_cosine_residual    = $signed(res_cos);
  assign out_partial_derivative = $signed(res_deriv);

endmodule

[rtl/core/lacg_front.sv]
// ----------------------------------------------------------------------------
// lacg_front: request intake and segment classification
// Takes a request, forms both direction vectors, flags zero-length segments
// and pre-scales overlong ones, then hands the record to the queue.
// ----------------------------------------------------------------------------
module lacg_front
  import lacg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_line1_start_x,
  input  logic signed [31:0] in_line1_start_y,
  input  logic signed [31:0] in_line1_end_x,
  input  logic signed [31:0] in_line1_end_y,
  input  logic signed [31:0] in_line2_start_x,
  input  logic signed [31:0] in_line2_start_y,
  input  logic signed [31:0] in_line2_end_x,
  input  logic signed [31:0] in_line2_end_y,
  input  logic [3:0]         in_wrt_coord,
  input  logic               q_full,
  output logic               q_push,
  output front_t             q_data
);

  function automatic nseg_t seg_class(logic signed [31:0] sx, logic signed [31:0] sy,
                                      logic signed [31:0] ex, logic signed [31:0] ey);
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] hx;
    logic signed [32:0] hy;
    logic [32:0]        ax;
    logic [32:0]        ay;
    logic [32:0]        m;
    nseg_t              r;
    dx = 33'(ex) - 33'(sx);
    dy = 33'(ey) - 33'(sy);
    ax = dx[32] ? 33'(-dx) : 33'(dx);
    ay = dy[32] ? 33'(-dy) : 33'(dy);
    m  = (ax > ay) ? ax : ay;
    // halving truncates toward zero
    hx = dx + $signed({32'd0, dx[32]});
    hy = dy + $signed({32'd0, dy[32]});
    r.half = m[32] | m[31];
    r.m    = m[30:0];
    r.lz   = 5'd0;
    if (r.half) begin
      r.x = 32'(hx >>> 1);
      r.y = 32'(hy >>> 1);
    end else begin
      r.x = dx[31:0];
      r.y = dy[31:0];
    end
    return r;
  endfunction

  logic   front_v_r, front_v_nxt;
  front_t front_d_r, front_d_nxt;
  logic   accept;
  nseg_t  c1, c2;

  assign busy   = front_v_r & q_full;
  assign accept = start & ~busy;
  assign q_push = front_v_r & ~q_full;
  assign q_data = front_d_r;

  always_comb begin
    c1 = seg_class(in_line1_start_x, in_line1_start_y, in_line1_end_x, in_line1_end_y);
    c2 = seg_class(in_line2_start_x, in_line2_start_y, in_line2_end_x, in_line2_end_y);
    front_v_nxt = accept | (front_v_r & q_full);
    front_d_nxt = front_d_r;
    if (accept) begin
      front_d_nxt.s1  = c1;
      front_d_nxt.s2  = c2;
      front_d_nxt.wrt = in_wrt_coord;
      front_d_nxt.deg = ((c1.m == 31'd0) && !c1.half) || ((c2.m == 31'd0) && !c2.half);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
    front_d_r <= front_d_nxt;
  end

endmodule

[rtl/core/lacg_queue.sv]
// ----------------------------------------------------------------------------
// lacg_queue: short request queue between front end and datapath
// Two-entry FIFO of classified records.
// ----------------------------------------------------------------------------
module lacg_queue
  import lacg_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  front_t din,
  input  logic   pop,
  output front_t dout,
  output logic   full,
  output logic   empty
);

  front_t     mem_r [QDEPTH];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign full   = (cnt_r == 2'(QDEPTH));
  assign empty  = (cnt_r == 2'd0);
  assign do_pop = pop & ~empty;
  assign dout   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

[rtl/core/lacg_back.sv]
// ----------------------------------------------------------------------------
// lacg_back: pipelined cosine and gradient datapath
// Normalise, square, square root, unit-vector divide, dot product, gradient
// term and final scaled divide, one request entering each cycle.
// ----------------------------------------------------------------------------
module lacg_back
  import lacg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_v,
  input  front_t      in_d,
  output logic        res_strobe,
  output logic [31:0] res_cos,
  output logic [31:0] res_deriv,
  output logic        res_deg
);

  localparam int NRM_STEPS  = 5;
  localparam int SQRT_STEPS = 32;
  localparam int UDIV_STEPS = 31;
  localparam int DDIV_STEPS = 34;

  typedef struct packed {
    logic [31:0] rem;
    logic [33:0] dnd;
    logic [33:0] q;
  } udiv_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [4:0]  lz;
    logic        half;
    logic [61:0] xx;
    logic [61:0] yy;
  } sq_seg_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [4:0]  lz;
    logic        half;
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } rt_seg_t;

  typedef struct packed {
    logic [31:0] n;
    logic [4:0]  lz;
    logic        half;
    logic        sx;
    logic        sy;
    udiv_t       dx;
    udiv_t       dy;
  } dv_seg_t;

  typedef struct packed {
    logic [31:0] n;
    logic [4:0]  lz;
    logic        half;
    logic [31:0] ux;
    logic [31:0] uy;
  } un_seg_t;

  typedef struct packed { logic v; logic deg; logic [3:0] wrt; nseg_t s1; nseg_t s2; } nrm_t;
  typedef struct packed { logic v; logic deg; logic [3:0] wrt; sq_seg_t s1; sq_seg_t s2; } sq_t;
  typedef struct packed { logic v; logic deg; logic [3:0] wrt; rt_seg_t s1; rt_seg_t s2; } rt_t;
  typedef struct packed { logic v; logic deg; logic [3:0] wrt; dv_seg_t s1; dv_seg_t s2; } dv_t;
  typedef struct packed { logic v; logic deg; logic [3:0] wrt; un_seg_t s1; un_seg_t s2; } un_t;

  typedef struct packed {
    logic        v;
    logic        deg;
    logic [3:0]  wrt;
    un_seg_t     s1;
    un_seg_t     s2;
    logic [61:0] p1;
    logic [61:0] p2;
  } cs1_t;

  typedef struct packed {
    logic        v;
    logic        deg;
    logic        dsel;
    logic        is_start;
    logic [31:0] cos;
    logic [31:0] oc;
    logic [31:0] pc;
    logic [31:0] n;
    logic [5:0]  k;
  } cs2_t;

  typedef struct packed {
    logic        v;
    logic        deg;
    logic        dsel;
    logic        is_start;
    logic [31:0] cos;
    logic [31:0] pc;
    logic [31:0] n;
    logic [5:0]  k;
    logic [61:0] pm;
  } cs3_t;

  typedef struct packed {
    logic        v;
    logic        deg;
    logic        dsel;
    logic        neg;
    logic [31:0] cos;
    logic [31:0] n;
    logic [5:0]  k;
    logic [31:0] mw;
  } wd_t;

  typedef struct packed {
    logic        v;
    logic        deg;
    logic        dsel;
    logic        neg;
    logic [31:0] cos;
    logic [31:0] n;
    udiv_t       d;
  } qd_t;

  // ---------------------------------------------------------------- helpers
  function automatic nseg_t nrm_step(nseg_t s, int sh);
    nseg_t r;
    r = s;
    if (!s.half && ((s.m >> (31 - sh)) == 31'd0)) begin
      r.m  = s.m << sh;
      r.x  = s.x << sh;
      r.y  = s.y << sh;
      r.lz = s.lz + 5'(sh);
    end
    return r;
  endfunction

  function automatic sq_seg_t sq_seg(nseg_t s);
    logic signed [63:0] px;
    logic signed [63:0] py;
    sq_seg_t            r;
    px     = 64'($signed(s.x)) * 64'($signed(s.x));
    py     = 64'($signed(s.y)) * 64'($signed(s.y));
    r.x    = s.x;
    r.y    = s.y;
    r.lz   = s.lz;
    r.half = s.half;
    r.xx   = px[61:0];
    r.yy   = py[61:0];
    return r;
  endfunction

  function automatic rt_seg_t rt_init(sq_seg_t s);
    rt_seg_t r;
    r.x    = s.x;
    r.y    = s.y;
    r.lz   = s.lz;
    r.half = s.half;
    r.rad  = {1'b0, 63'(s.xx) + 63'(s.yy)};
    r.rem  = 34'd0;
    r.root = 32'd0;
    return r;
  endfunction

  // two radicand bits per stage
  function automatic rt_seg_t rt_step(rt_seg_t s);
    logic [35:0] t;
    logic [35:0] tr;
    rt_seg_t     r;
    r  = s;
    t  = {s.rem, s.rad[63:62]};
    tr = {2'b00, s.root, 2'b01};
    if (t >= tr) begin
      r.rem  = 34'(t - tr);
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = t[33:0];
      r.root = {s.root[30:0], 1'b0};
    end
    r.rad = {s.rad[61:0], 2'b00};
    return r;
  endfunction

  function automatic udiv_t ud_init(logic [31:0] v);
    logic [30:0] ax;
    udiv_t       d;
    ax    = 31'(v[31] ? -v : v);
    d.rem = {2'b00, ax[30:1]};
    d.dnd = {ax[0], 33'd0};
    d.q   = 34'd0;
    return d;
  endfunction

  function automatic dv_seg_t dv_init(rt_seg_t s);
    dv_seg_t r;
    r.n    = s.root;
    r.lz   = s.lz;
    r.half = s.half;
    r.sx   = s.x[31];
    r.sy   = s.y[31];
    r.dx   = ud_init(s.x);
    r.dy   = ud_init(s.y);
    return r;
  endfunction

  function automatic udiv_t div_step(udiv_t d, logic [31:0] n);
    logic [32:0] t;
    logic        b;
    udiv_t       r;
    t = {d.rem, d.dnd[33]};
    b = (t >= {1'b0, n});
    r.rem = b ? 32'(t - {1'b0, n}) : t[31:0];
    r.dnd = {d.dnd[32:0], 1'b0};
    r.q   = {d.q[32:0], b};
    return r;
  endfunction

  // round to nearest on the remainder
  function automatic logic [34:0] div_fin(udiv_t d, logic [31:0] n);
    logic rnd;
    rnd = ({d.rem, 1'b0} >= {1'b0, n});
    return 35'(d.q) + 35'(rnd);
  endfunction

  function automatic logic [31:0] apply_sign(logic [34:0] q, logic neg);
    return neg ? 32'(-q) : 32'(q);
  endfunction

  function automatic un_seg_t un_fin(dv_seg_t s);
    un_seg_t r;
    r.n    = s.n;
    r.lz   = s.lz;
    r.half = s.half;
    r.ux   = apply_sign(div_fin(s.dx, s.n), s.sx);
    r.uy   = apply_sign(div_fin(s.dy, s.n), s.sy);
    return r;
  endfunction

  function automatic logic signed [32:0] rs30(logic signed [62:0] v);
    logic [62:0] mg;
    logic [32:0] m;
    mg = v[62] ? 63'(-v) : 63'(v);
    m  = 33'((mg + 63'd536870912) >> 30);
    return v[62] ? -$signed(m) : $signed(m);
  endfunction

  // ---------------------------------------------------------- normalising
  nrm_t nrm_src;
  nrm_t nrm_r [NRM_STEPS];

  always_comb begin
    nrm_src.v   = in_v;
    nrm_src.deg = in_d.deg;
    nrm_src.wrt = in_d.wrt;
    nrm_src.s1  = in_d.s1;
    nrm_src.s2  = in_d.s2;
  end

  for (genvar j = 0; j < NRM_STEPS; j++) begin : g_nrm
    nrm_t nrm_in, nrm_nxt;
    if (j == 0) begin : g_first
      assign nrm_in = nrm_src;
    end else begin : g_next
      assign nrm_in = nrm_r[j-1];
    end
    always_comb begin
      nrm_nxt    = nrm_in;
      nrm_nxt.s1 = nrm_step(nrm_in.s1, 16 >> j);
      nrm_nxt.s2 = nrm_step(nrm_in.s2, 16 >> j);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nrm_r[j].v <= 1'b0;
      end else begin
        nrm_r[j] <= nrm_nxt;
      end
    end
  end

  // ------------------------------------------------------- squares, sum
  sq_t sq_r, sq_nxt;
  rt_t rt0_r, rt0_nxt;

  always_comb begin
    sq_nxt.v   = nrm_r[NRM_STEPS-1].v;
    sq_nxt.deg = nrm_r[NRM_STEPS-1].deg;
    sq_nxt.wrt = nrm_r[NRM_STEPS-1].wrt;
    sq_nxt.s1  = sq_seg(nrm_r[NRM_STEPS-1].s1);
    sq_nxt.s2  = sq_seg(nrm_r[NRM_STEPS-1].s2);
    rt0_nxt.v   = sq_r.v;
    rt0_nxt.deg = sq_r.deg;
    rt0_nxt.wrt = sq_r.wrt;
    rt0_nxt.s1  = rt_init(sq_r.s1);
    rt0_nxt.s2  = rt_init(sq_r.s2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r.v  <= 1'b0;
      rt0_r.v <= 1'b0;
    end else begin
      sq_r  <= sq_nxt;
      rt0_r <= rt0_nxt;
    end
  end

  // ---------------------------------------------------------- square root
  rt_t rt_r [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_rt
    rt_t rt_in, rt_nxt;
    if (j == 0) begin : g_first
      assign rt_in = rt0_r;
    end else begin : g_next
      assign rt_in = rt_r[j-1];
    end
    always_comb begin
      rt_nxt    = rt_in;
      rt_nxt.s1 = rt_step(rt_in.s1);
      rt_nxt.s2 = rt_step(rt_in.s2);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_r[j].v <= 1'b0;
      end else begin
        rt_r[j] <= rt_nxt;
      end
    end
  end

  // ----------------------------------------------------- unit-vector divide
  dv_t dv0_r, dv0_nxt;
  dv_t dv_r [UDIV_STEPS];

  always_comb begin
    dv0_nxt.v   = rt_r[SQRT_STEPS-1].v;
    dv0_nxt.deg = rt_r[SQRT_STEPS-1].deg;
    dv0_nxt.wrt = rt_r[SQRT_STEPS-1].wrt;
    dv0_nxt.s1  = dv_init(rt_r[SQRT_STEPS-1].s1);
    dv0_nxt.s2  = dv_init(rt_r[SQRT_STEPS-1].s2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv0_r.v <= 1'b0;
    end else begin
      dv0_r <= dv0_nxt;
    end
  end

  for (genvar j = 0; j < UDIV_STEPS; j++) begin : g_dv
    dv_t dv_in, dv_nxt;
    if (j == 0) begin : g_first
      assign dv_in = dv0_r;
    end else begin : g_next
      assign dv_in = dv_r[j-1];
    end
    always_comb begin
      dv_nxt       = dv_in;
      dv_nxt.s1.dx = div_step(dv_in.s1.dx, dv_in.s1.n);
      dv_nxt.s1.dy = div_step(dv_in.s1.dy, dv_in.s1.n);
      dv_nxt.s2.dx = div_step(dv_in.s2.dx, dv_in.s2.n);
      dv_nxt.s2.dy = div_step(dv_in.s2.dy, dv_in.s2.n);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j].v <= 1'b0;
      end else begin
        dv_r[j] <= dv_nxt;
      end
    end
  end

  // ------------------------------------------- dot product, gradient term
  un_t  un_r, un_nxt;
  cs1_t cs1_r, cs1_nxt;
  cs2_t cs2_r, cs2_nxt;
  cs3_t cs3_r, cs3_nxt;
  wd_t  wd_r, wd_nxt;
  qd_t  qd0_r, qd0_nxt;

  logic signed [63:0] px1, px2, pxm;
  logic signed [62:0] dot;
  logic signed [32:0] cos_rnd, pm_rnd;
  logic signed [33:0] w;
  logic [63:0]        dd;
  un_seg_t            own, other;

  always_comb begin
    un_nxt.v   = dv_r[UDIV_STEPS-1].v;
    un_nxt.deg = dv_r[UDIV_STEPS-1].deg;
    un_nxt.wrt = dv_r[UDIV_STEPS-1].wrt;
    un_nxt.s1  = un_fin(dv_r[UDIV_STEPS-1].s1);
    un_nxt.s2  = un_fin(dv_r[UDIV_STEPS-1].s2);

    px1 = 64'($signed(un_r.s1.ux)) * 64'($signed(un_r.s2.ux));
    px2 = 64'($signed(un_r.s1.uy)) * 64'($signed(un_r.s2.uy));
    cs1_nxt.v   = un_r.v;
    cs1_nxt.deg = un_r.deg;
    cs1_nxt.wrt = un_r.wrt;
    cs1_nxt.s1  = un_r.s1;
    cs1_nxt.s2  = un_r.s2;
    cs1_nxt.p1  = px1[61:0];
    cs1_nxt.p2  = px2[61:0];

    // cosine, clamped to plus or minus one
    dot     = 63'($signed(cs1_r.p1)) + 63'($signed(cs1_r.p2));
    cos_rnd = rs30(dot);
    if (cos_rnd > 33'sd1073741824) begin
      cos_rnd = 33'sd1073741824;
    end else if (cos_rnd < -33'sd1073741824) begin
      cos_rnd = -33'sd1073741824;
    end
    own   = cs1_r.wrt[2] ? cs1_r.s2 : cs1_r.s1;
    other = cs1_r.wrt[2] ? cs1_r.s1 : cs1_r.s2;
    cs2_nxt.v        = cs1_r.v;
    cs2_nxt.deg      = cs1_r.deg;
    cs2_nxt.dsel     = ~cs1_r.wrt[3];
    cs2_nxt.is_start = ~cs1_r.wrt[1];
    cs2_nxt.cos      = 32'(cos_rnd);
    cs2_nxt.oc       = cs1_r.wrt[0] ? own.uy : own.ux;
    cs2_nxt.pc       = cs1_r.wrt[0] ? other.uy : other.ux;
    cs2_nxt.n        = own.n;
    cs2_nxt.k        = own.half ? 6'd1 : 6'(own.lz) + 6'd2;

    pxm = 64'($signed(cs2_r.cos)) * 64'($signed(cs2_r.oc));
    cs3_nxt.v        = cs2_r.v;
    cs3_nxt.deg      = cs2_r.deg;
    cs3_nxt.dsel     = cs2_r.dsel;
    cs3_nxt.is_start = cs2_r.is_start;
    cs3_nxt.cos      = cs2_r.cos;
    cs3_nxt.pc       = cs2_r.pc;
    cs3_nxt.n        = cs2_r.n;
    cs3_nxt.k        = cs2_r.k;
    cs3_nxt.pm       = pxm[61:0];

    pm_rnd = rs30(63'($signed(cs3_r.pm)));
    w      = 34'($signed(cs3_r.pc)) - 34'(pm_rnd);
    wd_nxt.v    = cs3_r.v;
    wd_nxt.deg  = cs3_r.deg;
    wd_nxt.dsel = cs3_r.dsel;
    wd_nxt.neg  = w[33] ^ cs3_r.is_start;
    wd_nxt.cos  = cs3_r.cos;
    wd_nxt.n    = cs3_r.n;
    wd_nxt.k    = cs3_r.k;
    wd_nxt.mw   = 32'(w[33] ? -w : w);

    dd = 64'(wd_r.mw) << wd_r.k;
    qd0_nxt.v     = wd_r.v;
    qd0_nxt.deg   = wd_r.deg;
    qd0_nxt.dsel  = wd_r.dsel;
    qd0_nxt.neg   = wd_r.neg;
    qd0_nxt.cos   = wd_r.cos;
    qd0_nxt.n     = wd_r.n;
    qd0_nxt.d.rem = {2'b00, dd[63:34]};
    qd0_nxt.d.dnd = dd[33:0];
    qd0_nxt.d.q   = 34'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      un_r.v  <= 1'b0;
      cs1_r.v <= 1'b0;
      cs2_r.v <= 1'b0;
      cs3_r.v <= 1'b0;
      wd_r.v  <= 1'b0;
      qd0_r.v <= 1'b0;
    end else begin
      un_r  <= un_nxt;
      cs1_r <= cs1_nxt;
      cs2_r <= cs2_nxt;
      cs3_r <= cs3_nxt;
      wd_r  <= wd_nxt;
      qd0_r <= qd0_nxt;
    end
  end

  // ------------------------------------------------ gradient scaled divide
  qd_t qd_r [DDIV_STEPS];

  for (genvar j = 0; j < DDIV_STEPS; j++) begin : g_qd
    qd_t qd_in, qd_nxt;
    if (j == 0) begin : g_first
      assign qd_in = qd0_r;
    end else begin : g_next
      assign qd_in = qd_r[j-1];
    end
    always_comb begin
      qd_nxt   = qd_in;
      qd_nxt.d = div_step(qd_in.d, qd_in.n);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qd_r[j].v <= 1'b0;
      end else begin
        qd_r[j] <= qd_nxt;
      end
    end
  end

  // ------------------------------------------------- saturate and output
  logic        strobe_r, strobe_nxt;
  logic [31:0] cos_r, cos_nxt;
  logic [31:0] deriv_r, deriv_nxt;
  logic        deg_r, deg_nxt;
  logic [34:0] qr;
  qd_t         fin;

  always_comb begin
    fin = qd_r[DDIV_STEPS-1];
    qr  = div_fin(fin.d, fin.n);
    if (fin.neg) begin
      deriv_nxt = (qr > 35'h080000000) ? 32'h80000000 : 32'(-qr);
    end else begin
      deriv_nxt = (qr > 35'h07fffffff) ? 32'h7fffffff : qr[31:0];
    end
    if (!fin.dsel || fin.deg) begin
      deriv_nxt = 32'd0;
    end
    cos_nxt    = fin.deg ? 32'd0 : fin.cos;
    deg_nxt    = fin.deg;
    strobe_nxt = fin.v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
    end
    cos_r   <= cos_nxt;
    deriv_r <= deriv_nxt;
    deg_r   <= deg_nxt;
  end

  assign res_strobe = strobe_r;
  assign res_cos    = cos_r;
  assign res_deriv  = deriv_r;
  assign res_deg    = deg_r;

endmodule

[verif/line_angle_cosine_gradient_chk.sv]
// ----------------------------------------------------------------------------
// line_angle_cosine_gradient_chk: result checker for the cosine gradient block
// Watches accepted requests, predicts cosine, gradient and degenerate flag in
// fixed point, and compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module line_angle_cosine_gradient_chk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] in_line1_start_x,
  input  logic signed [31:0] in_line1_start_y,
  input  logic signed [31:0] in_line1_end_x,
  input  logic signed [31:0] in_line1_end_y,
  input  logic signed [31:0] in_line2_start_x,
  input  logic signed [31:0] in_line2_start_y,
  input  logic signed [31:0] in_line2_end_x,
  input  logic signed [31:0] in_line2_end_y,
  input  logic [3:0]         in_wrt_coord,
  input  logic               out_strobe,
  input  logic signed [31:0] out_cosine_residual,
  input  logic signed [31:0] out_partial_derivative,
  input  logic               out_degenerate,
  output int                 mismatches,
  output int                 pending
);

  localparam longint Q30 = 64'sd1 <<< 30;
  localparam logic [3:0] WRT_NONE = 4'd8;

  typedef struct {
    logic signed [31:0] cosv;
    logic signed [31:0] grad;
    logic               deg;
  } angle_res_t;

  typedef struct {
    longint          ux;
    longint          uy;
    longint unsigned n;
    int              e;
  } unit_dir_t;

  angle_res_t angle_q[$];

  initial mismatches = 0;

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint rnd30(longint v);
    longint m;
    m = longint'((mag(v) + (64'd1 << 29)) >> 30);
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint div_rnd(longint a, longint unsigned n);
    longint m;
    m = longint'((mag(a) + n / 2) / n);
    return (a < 0) ? -m : m;
  endfunction

  function automatic bit unit_dir(longint x, longint y, output unit_dir_t u);
    longint unsigned m;
    int e;
    e = 0;
    u = '{0, 0, 0, 0};
    m = (mag(x) > mag(y)) ? mag(x) : mag(y);
    if (m == 0) return 0;
    if (m >= (64'd1 << 31)) begin
      // divide truncates toward zero, as the halving requires
      x = x / 2;
      y = y / 2;
      e = -1;
    end else begin
      while (m < (64'd1 << 30)) begin
        m <<= 1;
        e++;
      end
      x = x <<< e;
      y = y <<< e;
    end
    u.n  = int_sqrt(longint'(x * x) + longint'(y * y));
    u.e  = e;
    u.ux = div_rnd(x * Q30, u.n);
    u.uy = div_rnd(y * Q30, u.n);
    return 1;
  endfunction

  function automatic longint grad_scale(longint w, int k, longint unsigned n, bit neg);
    longint unsigned mw, q0, r, res, rk;
    bit negative;
    mw = mag(w);
    q0 = mw / n;
    r  = mw % n;
    negative = (w < 0) != neg;
    if ((q0 >> (32 - k)) != 0) begin
      res = 64'd1 << 32;
    end else begin
      rk  = r << k;
      res = (q0 << k) + rk / n + ((2 * (rk % n) >= n) ? 1 : 0);
    end
    if (negative) return (res > (64'd1 << 31)) ? -(64'sd1 <<< 31) : -longint'(res);
    return (res > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(res);
  endfunction

  function automatic angle_res_t predict_angle(longint c[8], logic [3:0] wrt);
    angle_res_t r;
    unit_dir_t v1, v2, own, oth;
    longint cosv, w, oc, pc;
    bit ok1, ok2;
    r = '{0, 0, 1'b1};
    ok1 = unit_dir(c[2] - c[0], c[3] - c[1], v1);
    ok2 = unit_dir(c[6] - c[4], c[7] - c[5], v2);
    if (!ok1 || !ok2) return r;
    cosv = rnd30(v1.ux * v2.ux + v1.uy * v2.uy);
    if (cosv > Q30)  cosv = Q30;
    if (cosv < -Q30) cosv = -Q30;
    r.deg  = 1'b0;
    r.cosv = cosv[31:0];
    if (wrt < WRT_NONE) begin
      own = wrt[2] ? v2 : v1;
      oth = wrt[2] ? v1 : v2;
      oc  = wrt[0] ? own.uy : own.ux;
      pc  = wrt[0] ? oth.uy : oth.ux;
      w   = pc - rnd30(cosv * oc);
      w   = grad_scale(w, own.e + 2, own.n, !wrt[1]);
      r.grad = w[31:0];
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    longint c[8];
    angle_res_t want;
    if (rst_n && start && !busy) begin
      c = '{in_line1_start_x, in_line1_start_y, in_line1_end_x, in_line1_end_y,
            in_line2_start_x, in_line2_start_y, in_line2_end_x, in_line2_end_y};
      angle_q.push_back(predict_angle(c, in_wrt_coord));
    end
    if (rst_n && out_strobe) begin
      if (angle_q.size() == 0) begin
        report("unexpected result", out_cosine_residual, 32'h0);
      end else begin
        want = angle_q.pop_front();
        if (out_cosine_residual !== want.cosv)
          report("cosine", out_cosine_residual, want.cosv);
        if (out_partial_derivative !== want.grad)
          report("gradient", out_partial_derivative, want.grad);
        if (out_degenerate !== want.deg)
          report("degenerate", 32'(out_degenerate), 32'(want.deg));
      end
    end
    pending = angle_q.size();
  end

endmodule

[verif/line_angle_cosine_gradient_tb.sv]
// ----------------------------------------------------------------------------
// line_angle_cosine_gradient_tb: stimulus and verdict for the gradient block
// Directed segment geometries then random requests under three idling mixes;
// checking is done by the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module line_angle_cosine_gradient_tb;

  localparam int N_RANDOM   = 1600;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN      = 130;

  typedef struct {
    logic signed [31:0] p[8];
    logic [3:0]         wrt;
  } seg_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] pt[8] = '{default: '0};
  logic [3:0] wrt = '0;
  logic out_strobe, out_degenerate;
  logic signed [31:0] out_cosine_residual, out_partial_derivative;
  int mismatches, pending;
  int idle_cycles = 0;
  int gap_pct = 0;

  always #1 clk = ~clk;

  line_angle_cosine_gradient dut (
    .clk, .rst_n, .start, .busy,
    .in_line1_start_x(pt[0]), .in_line1_start_y(pt[1]),
    .in_line1_end_x(pt[2]),   .in_line1_end_y(pt[3]),
    .in_line2_start_x(pt[4]), .in_line2_start_y(pt[5]),
    .in_line2_end_x(pt[6]),   .in_line2_end_y(pt[7]),
    .in_wrt_coord(wrt),
    .out_strobe, .out_cosine_residual, .out_partial_derivative, .out_degenerate
  );

  line_angle_cosine_gradient_chk chk (
    .clk, .rst_n, .start, .busy,
    .in_line1_start_x(pt[0]), .in_line1_start_y(pt[1]),
    .in_line1_end_x(pt[2]),   .in_line1_end_y(pt[3]),
    .in_line2_start_x(pt[4]), .in_line2_start_y(pt[5]),
    .in_line2_end_x(pt[6]),   .in_line2_end_y(pt[7]),
    .in_wrt_coord(wrt),
    .out_strobe, .out_cosine_residual, .out_partial_derivative, .out_degenerate,
    .mismatches, .pending
  );

  // watchdog: cycles with neither a request taken nor a result delivered
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("line_angle_cosine_gradient verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one request: raised at a rising edge, held until taken
  task automatic send(seg_pair_t s);
    start <= 1'b1;
    pt    <= s.p;
    wrt   <= s.wrt;
    @(negedge clk);
    while (busy) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    // each following cycle idles with probability gap_pct
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] near(logic signed [31:0] base);
    case ($urandom_range(3))
      0:       return base + $signed($urandom_range(0, 8)) - 4;
      1:       return base + $signed(32'($urandom_range(0, 32'h1_FFFF))) - 32'sh1_0000;
      2:       return base ^ (32'd1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  function automatic seg_pair_t rand_pair();
    seg_pair_t s;
    for (int i = 0; i < 8; i++) s.p[i] = $urandom;
    // mostly short segments near their start, some degenerate
    if ($urandom_range(99) < 60) begin
      s.p[2] = near(s.p[0]);
      s.p[3] = near(s.p[1]);
      s.p[6] = near(s.p[4]);
      s.p[7] = near(s.p[5]);
    end
    if ($urandom_range(99) < 5) begin
      s.p[2] = s.p[0];
      s.p[3] = s.p[1];
    end
    if ($urandom_range(99) < 5) begin
      s.p[6] = s.p[4];
      s.p[7] = s.p[5];
    end
    s.wrt = ($urandom_range(9) == 0) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(7));
    return s;
  endfunction

  function automatic seg_pair_t mk(int a0, int a1, int a2, int a3,
                                   int b0, int b1, int b2, int b3, logic [3:0] w);
    seg_pair_t s;
    s.p = '{a0, a1, a2, a3, b0, b1, b2, b3};
    s.wrt = w;
    return s;
  endfunction

  initial begin
    localparam int MX = 32'sh7FFF_FFFF;
    localparam int MN = 32'sh8000_0000;
    localparam int ONE = 32'sh0001_0000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(mk(0, 0, 0, 0, 0, 0, 0, 0, 4'd0));               // both zero length
    send(mk(5, 5, 5, 5, 0, 0, ONE, 0, 4'd2));             // first zero length
    send(mk(0, 0, ONE, 0, 7, 7, 7, 7, 4'd8));             // second zero length
    send(mk(MN, MN, MX, MX, MX, MN, MN, MX, 4'd2));       // full-span diagonals
    send(mk(MN, 0, MX, 0, MX, 0, MN, 0, 4'd6));           // antiparallel extreme
    send(mk(0, 0, ONE, 0, 0, 0, 2 * ONE, 0, 4'd1));       // parallel
    send(mk(0, 0, ONE, 0, 0, 0, 0, ONE, 4'd3));           // perpendicular
    send(mk(0, 0, 1, 0, 0, 0, 0, 1, 4'd4));               // one-LSB segments
    send(mk(0, 0, 1, 1, MX, MN, MN, MX, 4'd5));
    send(mk(MX, MX, MN, MN, 0, 0, 3, 1, 4'd7));
    for (int w = 0; w < 16; w++)
      send(mk(3 * ONE, -ONE, -2 * ONE, 5 * ONE, 0, ONE, 7 * ONE, -4 * ONE, 4'(w)));

    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 28 : (ph == 1) ? 79 : 0;
      wait_drained();
      for (int i = 0; i < N_RANDOM / 3; i++) send(rand_pair());
    end

    wait_drained();
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("line_angle_cosine_gradient verification clean");
    end else begin
      $display("line_angle_cosine_gradient verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/lacg_pkg.sv
rtl/core/lacg_front.sv
rtl/core/lacg_queue.sv
rtl/core/lacg_back.sv
rtl/core/line_angle_cosine_gradient.sv
verif/line_angle_cosine_gradient_chk.sv
verif/line_angle_cosine_gradient_tb.sv
